/* rtl/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define CHK_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define CHK_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/chte_pkg.sv */
// types, constants and helpers of the chained hash table engine
`default_nettype none
package chte_pkg;

    localparam int SLOTS  = 256;
    localparam int IDX_W  = 8;
    localparam int LINK_W = 9;
    localparam int KEY_W  = 32;
    localparam int CNT_W  = 9;

    localparam logic [LINK_W-1:0] NIL     = LINK_W'(SLOTS);
    localparam logic [CNT_W-1:0]  CNT_MAX = '1;

    localparam logic [1:0] REQ_ADD    = 2'd0;
    localparam logic [1:0] REQ_COUNT  = 2'd1;
    localparam logic [1:0] REQ_REMOVE = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_NOMATCH = 2'd2;

    typedef struct packed {
        logic [1:0]       req_type;
        logic [KEY_W-1:0] search_key;
        logic [IDX_W-1:0] home_slot;
    } req_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [CNT_W-1:0] match_count;
    } rsp_t;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  addr;
        logic [LINK_W-1:0] data;
    } link_wr_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] addr;
        logic             data;
    } used_wr_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] addr;
        logic [KEY_W-1:0] data;
    } key_wr_t;

    typedef struct packed {
        logic              used;
        logic [LINK_W-1:0] prev;
        logic [LINK_W-1:0] next;
        logic [KEY_W-1:0]  key;
    } row_t;

    function automatic logic [LINK_W-1:0] lnk(input logic [LINK_W-1:0] v);
        return (v > NIL) ? NIL : v;
    endfunction

    // writes aimed at the null link are dropped
    function automatic link_wr_t mk_link_wr(input logic [LINK_W-1:0] a,
                                            input logic [LINK_W-1:0] d);
        link_wr_t w;
        w.we   = (a != NIL);
        w.addr = a[IDX_W-1:0];
        w.data = d;
        return w;
    endfunction

endpackage
`default_nettype wire

/* rtl/chained_hash_table_engine.sv */
// top level of the chained hash table engine
// one request at a time: busy stays high from the accepting edge until done
// add runs LOOK, HEAD, then A_W2 (free home), TAKE to A_W3 (rent) or TAKE to A_W4 (evict);
// a refused add or unknown type ends in LOOK; count and remove walk the chain slot by slot
// the single registered read port of the slot memories sets the pace, done is never held off
// after reset busy stays high while a pass over all 256 slots rebuilds the free chain
`default_nettype none
module chained_hash_table_engine (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  chte_pkg::req_t   req,
    output logic             busy,
    output logic             done,
    output chte_pkg::rsp_t   rsp
);
    import chte_pkg::*;

    row_t             row;
    logic [IDX_W-1:0] rd_idx;
    used_wr_t         used_wr;
    link_wr_t         prev_wr;
    link_wr_t         next_wr;
    key_wr_t          key_wr;

    chte_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .req(req),
        .busy(busy), .done(done), .rsp(rsp), .row(row), .rd_idx(rd_idx),
        .used_wr(used_wr), .prev_wr(prev_wr), .next_wr(next_wr), .key_wr(key_wr)
    );

    chte_store u_store (
        .clk(clk), .rd_idx(rd_idx),
        .used_wr(used_wr), .prev_wr(prev_wr), .next_wr(next_wr), .key_wr(key_wr),
        .row(row)
    );

endmodule
`default_nettype wire

/* rtl/chte_ram.sv */
// generic single write, single read ram with registered read data
`default_nettype none
module chte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

/* rtl/chte_store.sv */
// slot store: key, used and link memories
`default_nettype none
module chte_store (
    input  logic                    clk,
    input  logic [7:0]              rd_idx,
    input  chte_pkg::used_wr_t      used_wr,
    input  chte_pkg::link_wr_t      prev_wr,
    input  chte_pkg::link_wr_t      next_wr,
    input  chte_pkg::key_wr_t       key_wr,
    output chte_pkg::row_t          row
);
    import chte_pkg::*;

    logic              used_q;
    logic [LINK_W-1:0] prev_q;
    logic [LINK_W-1:0] next_q;
    logic [KEY_W-1:0]  key_q;

    chte_ram #(.WIDTH(1), .DEPTH(SLOTS)) u_used (
        .clk(clk), .we(used_wr.we), .waddr(used_wr.addr), .wdata(used_wr.data),
        .raddr(rd_idx), .rdata(used_q)
    );

    chte_ram #(.WIDTH(LINK_W), .DEPTH(SLOTS)) u_prev (
        .clk(clk), .we(prev_wr.we), .waddr(prev_wr.addr), .wdata(prev_wr.data),
        .raddr(rd_idx), .rdata(prev_q)
    );

    chte_ram #(.WIDTH(LINK_W), .DEPTH(SLOTS)) u_next (
        .clk(clk), .we(next_wr.we), .waddr(next_wr.addr), .wdata(next_wr.data),
        .raddr(rd_idx), .rdata(next_q)
    );

    chte_ram #(.WIDTH(KEY_W), .DEPTH(SLOTS)) u_key (
        .clk(clk), .we(key_wr.we), .waddr(key_wr.addr), .wdata(key_wr.data),
        .raddr(rd_idx), .rdata(key_q)
    );

    always_comb
    begin
        row.used = used_q;
        row.prev = prev_q;
        row.next = next_q;
        row.key  = key_q;
    end

endmodule
`default_nettype wire

/* rtl/chte_ctrl.sv */
// request sequencer: chain walk, relinking and free list upkeep
`default_nettype none
module chte_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  chte_pkg::req_t          req,
    output logic                    busy,
    output logic                    done,
    output chte_pkg::rsp_t          rsp,
    input  chte_pkg::row_t          row,
    output logic [7:0]              rd_idx,
    output chte_pkg::used_wr_t      used_wr,
    output chte_pkg::link_wr_t      prev_wr,
    output chte_pkg::link_wr_t      next_wr,
    output chte_pkg::key_wr_t       key_wr
);
    import chte_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_LOOK  = 4'd1;
    localparam logic [3:0] S_HEAD  = 4'd2;
    localparam logic [3:0] S_TAKE  = 4'd3;
    localparam logic [3:0] S_WALK  = 4'd4;
    localparam logic [3:0] S_PROMO = 4'd5;
    localparam logic [3:0] S_A_W2  = 4'd6;
    localparam logic [3:0] S_A_W3  = 4'd7;
    localparam logic [3:0] S_A_W4  = 4'd8;
    localparam logic [3:0] S_G_W2  = 4'd9;
    localparam logic [3:0] S_G_W3  = 4'd10;
    localparam logic [3:0] S_CLR   = 4'd11;

    localparam logic [1:0] M_FREE  = 2'd0;
    localparam logic [1:0] M_RENT  = 2'd1;
    localparam logic [1:0] M_EVICT = 2'd2;

    logic [3:0]        state_reg,  state_next;
    req_t              req_reg,    req_next;
    logic [LINK_W-1:0] fh_reg,     fh_next;
    logic [LINK_W-1:0] total_reg,  total_next;
    logic [IDX_W-1:0]  clr_reg,    clr_next;
    logic [IDX_W-1:0]  cur_reg,    cur_next;
    logic [LINK_W-1:0] steps_reg,  steps_next;
    logic [CNT_W-1:0]  cnt_reg,    cnt_next;
    logic [IDX_W-1:0]  g_reg,      g_next;
    logic [LINK_W-1:0] hprev_reg,  hprev_next;
    logic [LINK_W-1:0] hnext_reg,  hnext_next;
    logic [KEY_W-1:0]  hkey_reg,   hkey_next;
    logic [1:0]        mode_reg,   mode_next;
    logic              done_reg,   done_next;
    rsp_t              rsp_reg,    rsp_next;

    logic [LINK_W-1:0] h_link;
    logic [LINK_W-1:0] nxt_link;
    logic [LINK_W-1:0] prv_link;
    logic [LINK_W-1:0] step_inc;
    logic [CNT_W-1:0]  cnt_new;
    logic              key_hit;
    logic              walk_end;
    logic              is_head;
    logic              do_visit;

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

    always_comb
    begin
        h_link   = {1'b0, req_reg.home_slot};
        nxt_link = lnk(row.next);
        prv_link = lnk(row.prev);
        step_inc = steps_reg + LINK_W'(1);
        key_hit  = (row.key == req_reg.search_key);
        walk_end = (nxt_link == NIL) || (step_inc == LINK_W'(SLOTS));
        is_head  = row.used && (prv_link == NIL);
        cnt_new  = cnt_reg;
        if ((req_reg.req_type == REQ_COUNT) && key_hit && (cnt_reg != CNT_MAX))
        begin
            cnt_new = cnt_reg + CNT_W'(1);
        end
        do_visit = 1'b0;

        state_next = state_reg;
        req_next   = req_reg;
        fh_next    = fh_reg;
        total_next = total_reg;
        clr_next   = clr_reg;
        cur_next   = cur_reg;
        steps_next = steps_reg;
        cnt_next   = cnt_reg;
        g_next     = g_reg;
        hprev_next = hprev_reg;
        hnext_next = hnext_reg;
        hkey_next  = hkey_reg;
        mode_next  = mode_reg;
        done_next  = 1'b0;
        rsp_next   = rsp_reg;

        rd_idx  = req_reg.home_slot;
        used_wr = '0;
        prev_wr = '0;
        next_wr = '0;
        key_wr  = '0;

        unique case (state_reg)
            S_CLR:
            begin
                // rebuild the free chain one slot per cycle
                used_wr.we   = 1'b1;
                used_wr.addr = clr_reg;
                used_wr.data = 1'b0;
                prev_wr      = mk_link_wr({1'b0, clr_reg},
                                          (clr_reg == '0) ? NIL
                                                          : ({1'b0, clr_reg} - LINK_W'(1)));
                next_wr      = mk_link_wr({1'b0, clr_reg}, {1'b0, clr_reg} + LINK_W'(1));
                clr_next     = clr_reg + IDX_W'(1);
                if (clr_reg == IDX_W'(SLOTS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    req_next   = req;
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                cur_next   = req_reg.home_slot;
                steps_next = '0;
                cnt_next   = '0;
                case (req_reg.req_type)
                    REQ_ADD:
                    begin
                        if (total_reg >= LINK_W'(SLOTS - 2))
                        begin
                            state_next           = S_IDLE;
                            done_next            = 1'b1;
                            rsp_next.status      = ST_FULL;
                            rsp_next.match_count = '0;
                        end
                        else
                        begin
                            total_next = total_reg + LINK_W'(1);
                            state_next = S_HEAD;
                        end
                    end
                    REQ_COUNT, REQ_REMOVE:
                    begin
                        state_next = S_HEAD;
                    end
                    default:
                    begin
                        state_next           = S_IDLE;
                        done_next            = 1'b1;
                        rsp_next.status      = ST_OK;
                        rsp_next.match_count = '0;
                    end
                endcase
            end
            S_HEAD:
            begin
                if (req_reg.req_type == REQ_ADD)
                begin
                    hprev_next = prv_link;
                    hnext_next = nxt_link;
                    hkey_next  = row.key;
                    if (!row.used)
                    begin
                        // unlink the home slot from the free list
                        if (prv_link != NIL)
                        begin
                            next_wr = mk_link_wr(prv_link, nxt_link);
                        end
                        else
                        begin
                            fh_next = nxt_link;
                        end
                        prev_wr      = mk_link_wr(nxt_link, prv_link);
                        used_wr.we   = 1'b1;
                        used_wr.addr = req_reg.home_slot;
                        used_wr.data = 1'b1;
                        key_wr.we    = 1'b1;
                        key_wr.addr  = req_reg.home_slot;
                        key_wr.data  = req_reg.search_key;
                        mode_next    = M_FREE;
                        state_next   = S_A_W2;
                    end
                    else
                    begin
                        rd_idx     = fh_reg[IDX_W-1:0];
                        mode_next  = (prv_link == NIL) ? M_RENT : M_EVICT;
                        state_next = S_TAKE;
                    end
                end
                else if (!is_head)
                begin
                    state_next           = S_IDLE;
                    done_next            = 1'b1;
                    rsp_next.status      = (req_reg.req_type == REQ_REMOVE) ? ST_NOMATCH
                                                                            : ST_OK;
                    rsp_next.match_count = '0;
                end
                else
                begin
                    do_visit = 1'b1;
                end
            end
            S_TAKE:
            begin
                g_next       = fh_reg[IDX_W-1:0];
                fh_next      = nxt_link;
                prev_wr      = mk_link_wr(nxt_link, NIL);
                next_wr      = mk_link_wr(fh_reg, hnext_reg);
                used_wr.we   = 1'b1;
                used_wr.addr = fh_reg[IDX_W-1:0];
                used_wr.data = 1'b1;
                key_wr.we    = 1'b1;
                key_wr.addr  = fh_reg[IDX_W-1:0];
                key_wr.data  = (mode_reg == M_EVICT) ? hkey_reg : req_reg.search_key;
                state_next   = S_A_W2;
            end
            S_A_W2:
            begin
                case (mode_reg)
                    M_RENT:
                    begin
                        prev_wr    = mk_link_wr({1'b0, g_reg}, h_link);
                        next_wr    = mk_link_wr(h_link, {1'b0, g_reg});
                        state_next = S_A_W3;
                    end
                    M_EVICT:
                    begin
                        prev_wr    = mk_link_wr({1'b0, g_reg}, hprev_reg);
                        next_wr    = mk_link_wr(hprev_reg, {1'b0, g_reg});
                        state_next = S_A_W3;
                    end
                    default:
                    begin
                        prev_wr              = mk_link_wr(h_link, NIL);
                        next_wr              = mk_link_wr(h_link, NIL);
                        state_next           = S_IDLE;
                        done_next            = 1'b1;
                        rsp_next.status      = ST_OK;
                        rsp_next.match_count = '0;
                    end
                endcase
            end
            S_A_W3:
            begin
                prev_wr = mk_link_wr(hnext_reg, {1'b0, g_reg});
                if (mode_reg == M_EVICT)
                begin
                    next_wr    = mk_link_wr(h_link, NIL);
                    state_next = S_A_W4;
                end
                else
                begin
                    state_next           = S_IDLE;
                    done_next            = 1'b1;
                    rsp_next.status      = ST_OK;
                    rsp_next.match_count = '0;
                end
            end
            S_A_W4:
            begin
                prev_wr              = mk_link_wr(h_link, NIL);
                key_wr.we            = 1'b1;
                key_wr.addr          = req_reg.home_slot;
                key_wr.data          = req_reg.search_key;
                state_next           = S_IDLE;
                done_next            = 1'b1;
                rsp_next.status      = ST_OK;
                rsp_next.match_count = '0;
            end
            S_WALK:
            begin
                do_visit = 1'b1;
            end
            S_PROMO:
            begin
                // next renter moves into the home slot
                next_wr      = mk_link_wr(h_link, nxt_link);
                prev_wr      = mk_link_wr(nxt_link, h_link);
                key_wr.we    = 1'b1;
                key_wr.addr  = req_reg.home_slot;
                key_wr.data  = row.key;
                used_wr.we   = 1'b1;
                used_wr.addr = g_reg;
                used_wr.data = 1'b0;
                state_next   = S_G_W2;
            end
            S_G_W2:
            begin
                prev_wr    = mk_link_wr({1'b0, g_reg}, NIL);
                next_wr    = mk_link_wr({1'b0, g_reg}, fh_reg);
                state_next = S_G_W3;
            end
            S_G_W3:
            begin
                prev_wr = mk_link_wr(fh_reg, {1'b0, g_reg});
                fh_next = {1'b0, g_reg};
                if (total_reg != '0)
                begin
                    total_next = total_reg - LINK_W'(1);
                end
                state_next           = S_IDLE;
                done_next            = 1'b1;
                rsp_next.status      = ST_OK;
                rsp_next.match_count = '0;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (do_visit)
        begin
            if ((req_reg.req_type == REQ_REMOVE) && key_hit)
            begin
                if (cur_reg != req_reg.home_slot)
                begin
                    next_wr      = mk_link_wr(prv_link, nxt_link);
                    prev_wr      = mk_link_wr(nxt_link, prv_link);
                    used_wr.we   = 1'b1;
                    used_wr.addr = cur_reg;
                    used_wr.data = 1'b0;
                    g_next       = cur_reg;
                    state_next   = S_G_W2;
                end
                else if (nxt_link != NIL)
                begin
                    rd_idx     = nxt_link[IDX_W-1:0];
                    g_next     = nxt_link[IDX_W-1:0];
                    state_next = S_PROMO;
                end
                else
                begin
                    used_wr.we   = 1'b1;
                    used_wr.addr = req_reg.home_slot;
                    used_wr.data = 1'b0;
                    g_next       = req_reg.home_slot;
                    state_next   = S_G_W2;
                end
            end
            else
            begin
                cnt_next   = cnt_new;
                steps_next = step_inc;
                if (walk_end)
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                    if (req_reg.req_type == REQ_COUNT)
                    begin
                        rsp_next.status      = ST_OK;
                        rsp_next.match_count = cnt_new;
                    end
                    else
                    begin
                        rsp_next.status      = ST_NOMATCH;
                        rsp_next.match_count = '0;
                    end
                end
                else
                begin
                    rd_idx     = nxt_link[IDX_W-1:0];
                    cur_next   = nxt_link[IDX_W-1:0];
                    state_next = S_WALK;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            fh_reg    <= '0;
            total_reg <= '0;
            clr_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fh_reg    <= fh_next;
            total_reg <= total_next;
            clr_reg   <= clr_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg   <= req_next;
        cur_reg   <= cur_next;
        steps_reg <= steps_next;
        cnt_reg   <= cnt_next;
        g_reg     <= g_next;
        hprev_reg <= hprev_next;
        hnext_reg <= hnext_next;
        hkey_reg  <= hkey_next;
        mode_reg  <= mode_next;
        rsp_reg   <= rsp_next;
    end

endmodule
`default_nettype wire

/* rtl/chte_checker.sv */
// port-level checker for the chained hash table engine and its bind
`default_nettype none
`include "assert_macros.svh"
module chte_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           start,
    input logic           busy,
    input logic           done,
    input chte_pkg::rsp_t rsp
);
    import chte_pkg::*;

    `CHK_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy, "not busy after accept")
    `CHK_NEXT(a_done_single, clk, rst_n, done, !done, "result beat repeated")
    `CHK_SAME(a_done_idle, clk, rst_n, done, !busy, "result beat while busy")
    `CHK_SAME(a_count_ok, clk, rst_n, done && (rsp.match_count != '0), rsp.status == ST_OK, "count with bad status")
    `CHK_SAME(a_status_code, clk, rst_n, done, rsp.status != 2'd3, "unknown status code")

endmodule

bind chained_hash_table_engine chte_checker u_chte_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done), .rsp(rsp)
);
`default_nettype wire
